// File: rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Default width of quaternion and vector components
  localparam int COMPONENT_BITS_DEF = 16;

  // Extra pipeline registers around the divider: input setup and output sign and saturation
  localparam int DIV_EXTRA_STAGES = 2;

  // Stages ahead of the divider: products, matrix, matrix*vector, sum
  localparam int FRONT_STAGES = 4;

endpackage

// File: rtl/qvr_div.sv
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider: round(num / den) to nearest, half away from
// zero, saturated to CB signed bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module qvr_div
  import qvr_pkg::*;
#(
  parameter int CB = COMPONENT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [3*CB+3:0] num,
  input  logic        [2*CB:0]   den,
  output logic                 sat,
  output logic signed [CB-1:0]   quo
);

  localparam int QB = CB + 1;        // quotient bits kept
  localparam int MW = 3 * CB + 4;    // numerator width
  localparam int NW = 2 * CB + 1;    // denominator width
  localparam int DW = NW + 1;        // doubled denominator
  localparam int RW = MW + 2;        // remainder width

  logic [RW-1:0] rem [0:QB];
  logic [DW-1:0] dd  [0:QB];
  logic [QB-1:0] qq  [0:QB];
  logic          ng  [0:QB];
  logic          ov  [0:QB];

  logic [MW-1:0] mag;
  logic [RW-1:0] n2;
  logic [DW-1:0] d2;
  logic [RW-1:0] lim;

  // setup: magnitude, 2|num|+den over 2*den, overflow check
  always_comb begin
    mag = num[MW-1] ? MW'(-num) : MW'(num);
    d2  = {den, 1'b0};
    n2  = {1'b0, mag, 1'b0} + RW'(den);
    lim = RW'(d2) << QB;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n2;
      dd[0]  <= d2;
      qq[0]  <= '0;
      ng[0]  <= num[MW-1];
      ov[0]  <= (n2 >= lim);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(dd[k]) << (QB - 1 - k);
    assign ge = (rem[k] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - sh : rem[k];
        qq[k+1]  <= qq[k] | (ge ? (QB'(1) << (QB - 1 - k)) : '0);
        dd[k+1]  <= dd[k];
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  // sign, saturation and output register
  localparam logic [QB-1:0] HALF = QB'(1) << (CB - 1);
  logic              sat_next;
  logic signed [CB-1:0] quo_next;

  always_comb begin
    if (ng[QB]) begin
      sat_next = ov[QB] || (qq[QB] > HALF);
      quo_next = sat_next ? {1'b1, {(CB-1){1'b0}}} : -(qq[QB][CB-1:0]);
    end else begin
      sat_next = ov[QB] || (qq[QB] > HALF - QB'(1));
      quo_next = sat_next ? {1'b0, {(CB-1){1'b1}}} : qq[QB][CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= sat_next;
      quo <= quo_next;
    end
  end

endmodule

// File: rtl/quaternion_vector_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a vector by a quaternion, q*(0,v)*conj(q)/|q|^2, rounded and
// saturated per component.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries quat_w..quat_z and vec_x..vec_z.
//   Output channel (out_valid/out_stall) carries rot_x..rot_z, saturated and
//   degenerate. A transaction completes on a clock edge with valid high and
//   stall low.
//   Pipeline: four stages build the rotation matrix and its product with the
//   vector, then a restoring divider retires one quotient bit per stage plus
//   a setup stage and a sign and saturation stage.
//   Throughput: one transaction per cycle unless the output stalls; every
//   stage is a plain register with a valid bit, so back-to-back items flow.
//   A stalled output freezes the whole pipeline; in_stall then goes high in
//   the same cycle so nothing is dropped or repeated.
//   A zero quaternion returns a zero vector with degenerate set.
//   Reset (rst, synchronous) clears all valid bits; data registers are not
//   reset.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation
  import qvr_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COMPONENT_BITS-1:0] quat_w,
  input  logic signed [COMPONENT_BITS-1:0] quat_x,
  input  logic signed [COMPONENT_BITS-1:0] quat_y,
  input  logic signed [COMPONENT_BITS-1:0] quat_z,
  input  logic signed [COMPONENT_BITS-1:0] vec_x,
  input  logic signed [COMPONENT_BITS-1:0] vec_y,
  input  logic signed [COMPONENT_BITS-1:0] vec_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COMPONENT_BITS-1:0] rot_x,
  output logic signed [COMPONENT_BITS-1:0] rot_y,
  output logic signed [COMPONENT_BITS-1:0] rot_z,
  output logic                          saturated,
  output logic                          degenerate
);

  localparam int CB = COMPONENT_BITS;
  localparam int PW = 2 * CB;          // quaternion product
  localparam int MB = 2 * CB + 2;      // matrix entry
  localparam int NW = 2 * CB + 1;      // norm squared
  localparam int VB = 3 * CB + 2;      // matrix * vector term
  localparam int SW = 3 * CB + 4;      // row sum
  localparam int P  = FRONT_STAGES + CB + 1 + DIV_EXTRA_STAGES;

  logic adv;
  logic [P-1:0] vld;
  logic [P-1:0] dg;

  // whole pipeline moves unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // valid and degenerate flags travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[P-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dg <= {dg[P-2:0], (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0)};
    end
  end

  // stage 1: quaternion products
  logic signed [PW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [CB-1:0] v1 [0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      ww <= quat_w * quat_w;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;
      xz <= quat_x * quat_z;
      yz <= quat_y * quat_z;
      wx <= quat_w * quat_x;
      wy <= quat_w * quat_y;
      wz <= quat_w * quat_z;
      v1[0] <= vec_x;
      v1[1] <= vec_y;
      v1[2] <= vec_z;
    end
  end

  // stage 2: rotation matrix scaled by |q|^2, and the norm
  logic signed [MB-1:0] eww, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
  logic signed [MB-1:0] mat [0:8];
  logic signed [MB-1:0] nsum;
  logic        [NW-1:0] n2;
  logic signed [CB-1:0] v2 [0:2];

  always_comb begin
    eww = MB'(ww); exx = MB'(xx); eyy = MB'(yy); ezz = MB'(zz);
    exy = MB'(xy); exz = MB'(xz); eyz = MB'(yz);
    ewx = MB'(wx); ewy = MB'(wy); ewz = MB'(wz);
    nsum = eww + exx + eyy + ezz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat[0] <= (eww + exx) - (eyy + ezz);
      mat[1] <= (exy - ewz) <<< 1;
      mat[2] <= (exz + ewy) <<< 1;
      mat[3] <= (exy + ewz) <<< 1;
      mat[4] <= (eww + eyy) - (exx + ezz);
      mat[5] <= (eyz - ewx) <<< 1;
      mat[6] <= (exz - ewy) <<< 1;
      mat[7] <= (eyz + ewx) <<< 1;
      mat[8] <= (eww + ezz) - (exx + eyy);
      n2     <= nsum[NW-1:0];
      v2     <= v1;
    end
  end

  // stage 3: matrix times vector terms
  logic signed [VB-1:0] term [0:8];
  logic        [NW-1:0] n3;

  for (genvar t = 0; t < 9; t++) begin : g_term
    always_ff @(posedge clk) begin
      if (adv) begin
        term[t] <= mat[t] * v2[t % 3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n3 <= n2;
    end
  end

  // stage 4: row sums
  logic signed [SW-1:0] row [0:2];
  logic        [NW-1:0] n4;

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (adv) begin
        row[r] <= SW'(term[3*r]) + SW'(term[3*r+1]) + SW'(term[3*r+2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n4 <= n3;
    end
  end

  // divide each row by |q|^2 with rounding and saturation
  logic              sat_c [0:2];
  logic signed [CB-1:0] quo_c [0:2];

  for (genvar r = 0; r < 3; r++) begin : g_div
    qvr_div #(
      .CB(CB)
    ) u_div (
      .clk(clk),
      .en (adv),
      .num(row[r]),
      .den(n4),
      .sat(sat_c[r]),
      .quo(quo_c[r])
    );
  end

  // output: a zero quaternion forces a zero vector
  assign out_valid  = vld[P-1];
  assign degenerate = dg[P-1];
  assign rot_x      = dg[P-1] ? '0 : quo_c[0];
  assign rot_y      = dg[P-1] ? '0 : quo_c[1];
  assign rot_z      = dg[P-1] ? '0 : quo_c[2];
  assign saturated  = !dg[P-1] && (sat_c[0] || sat_c[1] || sat_c[2]);

  // checks
  localparam logic signed [CB-1:0] SMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] SMIN = {1'b1, {(CB-1){1'b0}}};

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      rot_x == SMAX || rot_x == SMIN || rot_y == SMAX || rot_y == SMIN ||
      rot_z == SMAX || rot_z == SMIN)
    else $error("saturation flag without a clipped component");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !saturated && rot_x == '0 && rot_y == '0 && rot_z == '0)
    else $error("degenerate result not zero");

endmodule
